[hdl/scls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scls_pkg
// Shared types and constants of the sequence call/loop stack.
// ----------------------------------------------------------------------------
package scls_pkg;

  localparam int STACK_DEPTH = 8;
  // depth counter holds 0..STACK_DEPTH, index addresses 0..STACK_DEPTH-1
  localparam int PTR_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 16;
  localparam int DEPTH_W = 4;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_CALL       = 2'd0;
  localparam kind_t KIND_LOOP_START = 2'd1;
  localparam kind_t KIND_LOOP_END   = 2'd2;
  localparam kind_t KIND_RETURN     = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;   // register the input transaction
    logic execute;   // update the stack and load the result registers
  } scls_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic result_ok;
  } scls_status_t;

endpackage

[hdl/sequence_call_loop_stack_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_call_loop_stack_top
// Control-flow stack of a sequence command reader.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries kind, cur_pos and operand.
//   Output channel (out_valid / out_stall) returns ok, jump, new_pos and
//   depth, one result transaction per input transaction, in order.
//   cfg_wen / cfg_wdata write base_address, added to call offsets; write it
//   only while no command is in flight.
//   Timing: a command is taken in the idle state, executed in the next
//   cycle and offered in the cycle after that. The sequencer handles one
//   command at a time.
//   While a result waits, in_stall stays high and the result holds.
//   Reset (rst, synchronous) empties the stack, clears all loop counts and
//   base_address; no command is in flight afterwards.
// ----------------------------------------------------------------------------
module sequence_call_loop_stack_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [31:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  scls_pkg::kind_t        kind,
  input  logic [31:0]            cur_pos,
  input  logic [31:0]            operand,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   ok,
  output logic                   jump,
  output logic [31:0]            new_pos,
  output logic [3:0]             depth
);
  import scls_pkg::*;

  scls_cmd_t    cmd;
  scls_status_t status;

  scls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  scls_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .kind      (kind),
    .cur_pos   (cur_pos),
    .operand   (operand),
    .ok        (ok),
    .jump      (jump),
    .new_pos   (new_pos),
    .depth     (depth)
  );

endmodule

[hdl/scls_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scls_ctrl
// Sequencer: take one command, execute it, hold the result until taken.
// ----------------------------------------------------------------------------
module scls_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output scls_pkg::scls_cmd_t   cmd,
  input  scls_pkg::scls_status_t status
);
  import scls_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall    = (state != ST_IDLE);
  assign out_valid   = (state == ST_OUT);
  assign cmd.capture = (state == ST_IDLE) && in_valid;
  assign cmd.execute = (state == ST_EXEC);

  // a result is offered only right after an execute step or while it is held
  a_out_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.execute))
    else $error("result offered without an execute step");

  // capture only in the idle state, never beside an execute or a held result
  a_no_capture_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !out_valid && !cmd.execute)
    else $error("capture while busy");

  a_status_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid) |-> $stable(status.result_ok))
    else $error("result status changed while held");

endmodule

[hdl/scls_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scls_datapath
// Return address and loop count stack, base register and result registers.
// ----------------------------------------------------------------------------
module scls_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  scls_pkg::scls_cmd_t    cmd,
  output scls_pkg::scls_status_t status,
  input  logic                   cfg_wen,
  input  logic [31:0]            cfg_wdata,
  input  scls_pkg::kind_t        kind,
  input  logic [31:0]            cur_pos,
  input  logic [31:0]            operand,
  output logic                   ok,
  output logic                   jump,
  output logic [31:0]            new_pos,
  output logic [3:0]             depth
);
  import scls_pkg::*;

  logic [ADDR_W-1:0]  base_address;
  kind_t              kind_r;
  logic [ADDR_W-1:0]  pos_r;
  logic [ADDR_W-1:0]  opnd_r;
  logic [PTR_W-1:0]   sdepth;

  logic [ADDR_W-1:0]  ret_addr [STACK_DEPTH];
  logic [COUNT_W-1:0] loop_cnt [STACK_DEPTH];

  logic               full;
  logic               empty;
  logic [PTR_W-1:0]   top_ptr;
  logic [IDX_W-1:0]   top_idx;
  logic [IDX_W-1:0]   push_idx;
  logic [COUNT_W-1:0] top_cnt;
  logic [COUNT_W-1:0] dec_cnt;

  logic               ok_next;
  logic               jump_next;
  logic [ADDR_W-1:0]  pos_next;
  logic [PTR_W-1:0]   sdepth_next;
  logic               push_ret;
  logic               push_cnt;
  logic               store_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (cfg_wen) begin
      base_address <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind;
      pos_r  <= cur_pos;
      opnd_r <= operand;
    end
  end

  assign full     = (sdepth >= PTR_W'(STACK_DEPTH));
  assign empty    = (sdepth == '0);
  assign top_ptr  = sdepth - PTR_W'(1);
  assign top_idx  = top_ptr[IDX_W-1:0];
  assign push_idx = sdepth[IDX_W-1:0];
  assign top_cnt  = loop_cnt[top_idx];
  // a zero count stays zero
  assign dec_cnt  = (top_cnt != '0) ? top_cnt - COUNT_W'(1) : '0;

  always_comb begin
    ok_next     = 1'b1;
    jump_next   = 1'b0;
    pos_next    = pos_r;
    sdepth_next = sdepth;
    push_ret    = 1'b0;
    push_cnt    = 1'b0;
    store_cnt   = 1'b0;
    case (kind_r)
      KIND_CALL, KIND_LOOP_START: begin
        if (full) begin
          ok_next = 1'b0;
        end else begin
          push_ret    = 1'b1;
          sdepth_next = sdepth + PTR_W'(1);
          if (kind_r == KIND_CALL) begin
            pos_next  = base_address + opnd_r;
            jump_next = 1'b1;
          end else begin
            push_cnt = 1'b1;
          end
        end
      end
      KIND_LOOP_END: begin
        if (empty) begin
          ok_next = 1'b0;
        end else if (dec_cnt == '0) begin
          sdepth_next = top_ptr;
        end else begin
          store_cnt = 1'b1;
          pos_next  = ret_addr[top_idx];
          jump_next = 1'b1;
        end
      end
      default: begin
        if (empty) begin
          ok_next = 1'b0;
        end else begin
          sdepth_next = top_ptr;
          pos_next    = ret_addr[top_idx];
          jump_next   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sdepth <= '0;
    end else if (cmd.execute) begin
      sdepth <= sdepth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && push_ret) begin
      ret_addr[push_idx] <= pos_r;
    end
  end

  // counts reset to zero: a loop end on a call slot reads what is left there
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        loop_cnt[i] <= '0;
      end
    end else if (cmd.execute) begin
      if (push_cnt) begin
        loop_cnt[push_idx] <= opnd_r[COUNT_W-1:0];
      end else if (store_cnt) begin
        loop_cnt[top_idx] <= dec_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      ok      <= ok_next;
      jump    <= jump_next;
      new_pos <= pos_next;
      depth   <= DEPTH_W'(sdepth_next);
    end
  end

  assign status.result_ok = ok;

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    sdepth <= PTR_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_fail_keeps_depth: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && !ok_next |=> $stable(sdepth))
    else $error("failed command changed the stack depth");

  a_jump_needs_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> (!jump || ok))
    else $error("jump reported on a failed command");

  a_fallthrough_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && !jump_next |=> new_pos == $past(pos_r))
    else $error("fall-through position differs from current position");

endmodule
